// ===== src/terminal_line_editor_assert.svh =====
// assertion macros for the checker file of the terminal line editor
// expects clk and rst to be visible where a macro is used
`ifndef TERMINAL_LINE_EDITOR_ASSERT_SVH
`define TERMINAL_LINE_EDITOR_ASSERT_SVH

// checked on every rising edge, switched off while rst is high
`define TLE_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("terminal line editor check failed");

// checked on every rising edge, reset included
`define TLE_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("terminal line editor reset check failed");

`endif

// ===== src/tle_pkg.sv =====
// shared types and constants of the terminal line editor
// no dependencies; imported by every module of the block
`default_nettype none

package tle_pkg;

  localparam int LINE_BUFFER_BYTES = 32;
  localparam int ADDR_W            = $clog2(LINE_BUFFER_BYTES);
  localparam int CNT_W             = 6;
  localparam int ECHO_W            = 3;
  localparam int CMD_DEPTH         = 4;
  localparam int OUT_DEPTH         = 3;

  localparam logic [CNT_W-1:0]  LINE_LIMIT_RESET = 6'd32;
  localparam logic [ECHO_W-1:0] TAB_SPACES       = 3'd4;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_UP  = 8'h41;

  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_LINE = 1'b1;

  typedef enum logic [1:0] {
    OP_RECALL = 2'd0,
    OP_BS     = 2'd1,
    OP_TAB    = 2'd2,
    OP_CHAR   = 2'd3
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] ch;
  } cmd_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== src/terminal_line_editor.sv =====
// a byte's result passes the command queue, sequencer, read stage and output queue
// the back end executes one command at a time and takes the next one only after
//   the last beat has left the read stage; worst case 33 results per command,
//   with one store read and one beat per cycle while the output queue has room
// bytes that make no result (nul, escape) stay in the front end, no command is queued
// reset: synchronous rst clears control state, no clearing pass
`default_nettype none

// top level: front end, command queue, back end and the line_limit register
// depends on tle_pkg, tle_front, tle_cmd_fifo, tle_back
module terminal_line_editor import tle_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // received bytes
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       rx_byte,
  // echo and line beats
  output logic             out_valid,
  input  logic             out_ready,
  output logic             kind,
  output logic [7:0]       data_byte,
  output logic             last,
  // line_limit register
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data
);

  logic [CNT_W-1:0] line_limit;

  // front end to queue
  logic cmd_push;
  logic cmd_space;
  cmd_t cmd_in;

  // queue to back end
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd_head;

  out_beat_t out_beat;

  // caller buffer size, clamped inside the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= LINE_LIMIT_RESET;
    end else if (cfg_we) begin
      line_limit <= cfg_data;
    end
  end

  // escape tracking and byte classification, one byte per cycle while the queue has space
  tle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .cmd_space (cmd_space),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  // decouples input acceptance from long echo or delivery bursts
  tle_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (cmd_in),
    .space    (cmd_space),
    .pop      (cmd_pop),
    .valid    (cmd_valid),
    .head     (cmd_head)
  );

  // edit sequencer with the line and history stores and the output queue
  tle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .line_limit (line_limit),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd_head),
    .cmd_pop    (cmd_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_beat   (out_beat)
  );

  // result beat fields
  assign kind      = out_beat.kind;
  assign data_byte = out_beat.data;
  assign last      = out_beat.last;

endmodule

`default_nettype wire

// ===== src/tle_front.sv =====
// front end: accepts received bytes, swallows escape sequences, classifies
// each byte into a command for the queue; uses tle_pkg
`default_nettype none

module tle_front import tle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       cmd_space,
  output logic       cmd_push,
  output cmd_t       cmd
);

  logic [1:0] esc_skip;
  logic [1:0] esc_skip_next;
  logic       accept;

  assign in_ready = cmd_space;
  assign accept   = in_valid && in_ready;

  always_comb begin
    esc_skip_next = esc_skip;
    cmd_push      = 1'b0;
    cmd.op        = OP_CHAR;
    cmd.ch        = rx_byte;
    if (accept) begin
      if (esc_skip != 2'd0) begin
        esc_skip_next = esc_skip - 2'd1;
        // second byte after esc: up-arrow candidate
        if (esc_skip == 2'd1 && rx_byte == CH_UP) begin
          cmd.op   = OP_RECALL;
          cmd_push = 1'b1;
        end
      end else begin
        case (rx_byte)
          CH_BS: begin
            cmd.op   = OP_BS;
            cmd_push = 1'b1;
          end
          CH_TAB: begin
            cmd.op   = OP_TAB;
            cmd_push = 1'b1;
          end
          CH_ESC: begin
            esc_skip_next = 2'd2;
          end
          CH_NUL: begin
          end
          default: begin
            cmd.op   = OP_CHAR;
            cmd_push = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_skip <= 2'd0;
    end else begin
      esc_skip <= esc_skip_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/tle_cmd_fifo.sv =====
// short command queue between the front end and the back end
// uses tle_pkg for the command type and depth
`default_nettype none

module tle_cmd_fifo import tle_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic space,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  localparam int PTR_W = $clog2(CMD_DEPTH);
  localparam int FCNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t              slots [CMD_DEPTH];
  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  rp;
  logic [FCNT_W-1:0] cnt;

  assign space = cnt != FCNT_W'(CMD_DEPTH);
  assign valid = cnt != '0;
  assign head  = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        slots[wp] <= push_cmd;
        wp <= (wp == PTR_W'(CMD_DEPTH - 1)) ? '0 : wp + PTR_W'(1);
      end
      if (pop) begin
        rp <= (rp == PTR_W'(CMD_DEPTH - 1)) ? '0 : rp + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + FCNT_W'(1);
      end else if (pop && !push) begin
        cnt <= cnt - FCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/tle_back.sv =====
// back end: line and history stores, edit sequencer, read stage and output
// queue; executes one command at a time; uses tle_pkg
`default_nettype none

module tle_back import tle_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] line_limit,
  input  logic             cmd_valid,
  input  cmd_t             cmd,
  output logic             cmd_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output out_beat_t        out_beat
);

  localparam int OPTR_W = $clog2(OUT_DEPTH);
  localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_ECHO    = 4'b0010,
    S_RECALL  = 4'b0100,
    S_DELIVER = 4'b1000
  } back_state_t;

  typedef enum logic [1:0] {
    SEL_IMM  = 2'd0,
    SEL_LINE = 2'd1,
    SEL_HIST = 2'd2
  } src_sel_t;

  back_state_t       state;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  hist_len;
  logic [CNT_W-1:0]  run_cnt;
  logic [CNT_W-1:0]  hist_cnt;
  logic [CNT_W-1:0]  idx;
  logic [7:0]        e0;
  logic [7:0]        e1;
  logic [7:0]        e2;
  logic [ECHO_W-1:0] echo_n;
  logic [ECHO_W-1:0] echo_i;
  logic              echo_tab;

  logic [7:0] line_mem [LINE_BUFFER_BYTES];
  logic [7:0] hist_mem [LINE_BUFFER_BYTES];
  logic [7:0] line_rdata;
  logic [7:0] hist_rdata;

  // read stage
  logic              b_valid;
  src_sel_t          b_sel;
  logic [7:0]        b_byte;
  logic              b_kind;
  logic              b_last;
  logic              b_lwr;
  logic              b_hwr;
  logic [ADDR_W-1:0] b_idx;
  logic [7:0]        b_data;

  // output queue
  out_beat_t         obuf [OUT_DEPTH];
  logic [OPTR_W-1:0] owp;
  logic [OPTR_W-1:0] orp;
  logic [OCNT_W-1:0] ocnt;
  logic              opop;

  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  lim_m1;
  logic [CNT_W-1:0]  nf;
  logic [CNT_W-1:0]  room;
  logic [ECHO_W-1:0] tab_k;
  logic              has_room;
  logic              fill_ok;
  logic              is_term;
  logic              full_hit;
  logic              issue_ok;
  logic              echo_end;
  logic              run_end;
  logic [7:0]        echo_byte;

  logic              line_we;
  logic [ADDR_W-1:0] line_wa;
  logic [7:0]        line_wd;
  logic              hist_we;

  always_comb begin
    if (line_limit < CNT_W'(2)) begin
      lim = CNT_W'(2);
    end else if (line_limit > CNT_W'(LINE_BUFFER_BYTES)) begin
      lim = CNT_W'(LINE_BUFFER_BYTES);
    end else begin
      lim = line_limit;
    end
  end

  assign lim_m1   = lim - CNT_W'(1);
  assign fill_ok  = fill < CNT_W'(LINE_BUFFER_BYTES);
  assign nf       = fill_ok ? fill + CNT_W'(1) : fill;
  assign is_term  = cmd.ch == CH_CR || cmd.ch == CH_LF;
  assign full_hit = nf >= lim_m1;
  assign has_room = ({1'b0, fill} + (CNT_W + 1)'(2)) < {1'b0, lim};
  assign room     = lim - fill - CNT_W'(2);

  always_comb begin
    if (!has_room) begin
      tab_k = '0;
    end else if (room > CNT_W'(TAB_SPACES)) begin
      tab_k = TAB_SPACES;
    end else begin
      tab_k = room[ECHO_W-1:0];
    end
  end

  // keep a free output slot for every beat in flight
  assign issue_ok = ((OCNT_W + 1)'(ocnt) + (OCNT_W + 1)'(b_valid)) < (OCNT_W + 1)'(OUT_DEPTH);
  // no pop while the read stage may still write a store
  assign cmd_pop  = state == S_IDLE && cmd_valid && !b_valid;
  assign echo_end = echo_i == echo_n - ECHO_W'(1);
  assign run_end  = idx == run_cnt - CNT_W'(1);

  always_comb begin
    if (echo_tab) begin
      echo_byte = CH_SP;
    end else begin
      case (echo_i)
        ECHO_W'(0): echo_byte = e0;
        ECHO_W'(1): echo_byte = e1;
        default:    echo_byte = e2;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      hist_len <= '0;
      b_valid  <= 1'b0;
    end else begin
      b_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            echo_i   <= '0;
            echo_tab <= 1'b0;
            idx      <= '0;
            case (cmd.op)
              OP_RECALL: begin
                if (fill == '0 && hist_len != '0) begin
                  fill    <= hist_len;
                  run_cnt <= hist_len;
                  state   <= S_RECALL;
                end
              end
              OP_BS: begin
                if (fill != '0) begin
                  fill    <= fill - CNT_W'(1);
                  e0      <= CH_BS;
                  e1      <= CH_SP;
                  e2      <= CH_BS;
                  echo_n  <= ECHO_W'(3);
                  run_cnt <= '0;
                  state   <= S_ECHO;
                end
              end
              OP_TAB: begin
                if (tab_k != '0) begin
                  echo_n   <= tab_k;
                  echo_tab <= 1'b1;
                  run_cnt  <= '0;
                  state    <= S_ECHO;
                end
              end
              OP_CHAR: begin
                e0     <= is_term ? CH_CR : cmd.ch;
                e1     <= CH_LF;
                echo_n <= is_term ? ECHO_W'(2) : ECHO_W'(1);
                state  <= S_ECHO;
                if (full_hit) begin
                  run_cnt  <= lim_m1;
                  hist_cnt <= lim_m1;
                  hist_len <= lim_m1;
                  fill     <= '0;
                end else if (is_term) begin
                  run_cnt  <= nf;
                  hist_cnt <= (nf > CNT_W'(1)) ? nf - CNT_W'(1) : '0;
                  if (nf > CNT_W'(1)) begin
                    hist_len <= nf - CNT_W'(1);
                  end
                  fill     <= '0;
                end else begin
                  run_cnt <= '0;
                  fill    <= nf;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_ECHO: begin
          if (issue_ok) begin
            b_valid <= 1'b1;
            b_sel   <= SEL_IMM;
            b_byte  <= echo_byte;
            b_kind  <= KIND_ECHO;
            b_last  <= echo_end && run_cnt == '0;
            b_lwr   <= 1'b0;
            b_hwr   <= 1'b0;
            echo_i  <= echo_i + ECHO_W'(1);
            if (echo_tab) begin
              fill <= fill + CNT_W'(1);
            end
            if (echo_end) begin
              state <= (run_cnt != '0) ? S_DELIVER : S_IDLE;
            end
          end
        end
        S_RECALL: begin
          if (issue_ok) begin
            b_valid <= 1'b1;
            b_sel   <= SEL_HIST;
            b_kind  <= KIND_ECHO;
            b_last  <= run_end;
            b_lwr   <= 1'b1;
            b_hwr   <= 1'b0;
            b_idx   <= idx[ADDR_W-1:0];
            idx     <= idx + CNT_W'(1);
            if (run_end) begin
              state <= S_IDLE;
            end
          end
        end
        S_DELIVER: begin
          if (issue_ok) begin
            b_valid <= 1'b1;
            b_sel   <= SEL_LINE;
            b_kind  <= KIND_LINE;
            b_last  <= run_end;
            b_lwr   <= 1'b0;
            b_hwr   <= idx < hist_cnt;
            b_idx   <= idx[ADDR_W-1:0];
            idx     <= idx + CNT_W'(1);
            if (run_end) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // line store write port: recall copy, typed byte, tab space
  always_comb begin
    line_we = 1'b0;
    line_wa = fill[ADDR_W-1:0];
    line_wd = CH_SP;
    if (b_valid && b_lwr) begin
      line_we = 1'b1;
      line_wa = b_idx;
      line_wd = hist_rdata;
    end else if (cmd_pop && cmd.op == OP_CHAR && fill_ok) begin
      line_we = 1'b1;
      line_wd = cmd.ch;
    end else if (state == S_ECHO && issue_ok && echo_tab) begin
      line_we = 1'b1;
    end
  end

  assign hist_we = b_valid && b_hwr;

  always_ff @(posedge clk) begin
    line_rdata <= line_mem[idx[ADDR_W-1:0]];
    hist_rdata <= hist_mem[idx[ADDR_W-1:0]];
    if (line_we) begin
      line_mem[line_wa] <= line_wd;
    end
    if (hist_we) begin
      hist_mem[b_idx] <= line_rdata;
    end
  end

  always_comb begin
    case (b_sel)
      SEL_LINE: b_data = line_rdata;
      SEL_HIST: b_data = hist_rdata;
      default:  b_data = b_byte;
    endcase
  end

  // output queue
  assign out_valid = ocnt != '0;
  assign out_beat  = obuf[orp];
  assign opop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= '0;
      orp  <= '0;
      ocnt <= '0;
    end else begin
      if (b_valid) begin
        obuf[owp] <= '{kind: b_kind, data: b_data, last: b_last};
        owp <= (owp == OPTR_W'(OUT_DEPTH - 1)) ? '0 : owp + OPTR_W'(1);
      end
      if (opop) begin
        orp <= (orp == OPTR_W'(OUT_DEPTH - 1)) ? '0 : orp + OPTR_W'(1);
      end
      if (b_valid && !opop) begin
        ocnt <= ocnt + OCNT_W'(1);
      end else if (opop && !b_valid) begin
        ocnt <= ocnt - OCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/tle_checker.sv =====
// port-level checks of the terminal line editor, bound to the top level
// depends on terminal_line_editor_assert.svh and terminal_line_editor
`default_nettype none

`include "terminal_line_editor_assert.svh"

module tle_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       kind,
  input logic [7:0] data_byte,
  input logic       last
);

  // queues come out of reset empty
  `TLE_ASSERT_ALWAYS(a_rst_out_empty, rst |=> !out_valid)
  `TLE_ASSERT_ALWAYS(a_rst_in_ready, rst |=> in_ready)

  // a stalled result beat holds
  `TLE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  `TLE_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable({kind, data_byte, last}))

endmodule

bind terminal_line_editor tle_checker u_tle_checker (.*);

`default_nettype wire

// ===== sim/terminal_line_editor_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for terminal_line_editor: raw terminal bytes in, echo and
// line beats out, every beat checked against a byte-level line editing model
// depends on tle_pkg and the terminal_line_editor rtl

module terminal_line_editor_tb;
  import tle_pkg::*;

  localparam int WATCHDOG_CYCLES = 2_000_000;
  localparam int HOLD_CYCLES     = 700;   // long output stall to back up the block
  localparam int SETTLE_CYCLES   = 12;    // margin for the pipeline and for nul and escape bytes
  localparam int PHASE_ITEMS     = 45;
  localparam int MAX_STEP_BEATS  = 40;
  localparam int N_ROWS          = 25;
  localparam int N_PHASES        = 10;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic [7:0]       rx_byte   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             kind;
  logic [7:0]       data_byte;
  logic             last;
  logic             cfg_we    = 1'b0;
  logic [CNT_W-1:0] cfg_data  = '0;

  // knobs shared by the driving processes
  bit no_idle  = 1'b0;
  bit hold_req = 1'b0;

  // run bookkeeping
  int cycles     = 0;
  int mismatches = 0;
  int bytes_in   = 0;
  int echo_beats = 0;
  int line_beats = 0;

  // editor state as the model sees it
  logic [1:0]       esc_left  = '0;
  logic [CNT_W-1:0] fill      = '0;
  logic [CNT_W-1:0] hist_len  = '0;
  logic [CNT_W-1:0] limit_reg = LINE_LIMIT_RESET;
  logic [7:0]       line_buf [LINE_BUFFER_BYTES];
  logic [7:0]       hist_buf [LINE_BUFFER_BYTES];

  // beats caused by the byte just accepted, then the queue of beats still owed
  out_beat_t step_beats [MAX_STEP_BEATS];
  int        step_n = 0;
  out_beat_t pending_beats [$];

  // directed bytes; where pin is set, the beat count and first beat are known up front
  typedef struct packed {
    logic [7:0] rx;
    logic       pin;
    logic [5:0] n;
    logic       kind;
    logic [7:0] data;
  } edit_row_t;

  edit_row_t dir_rows [N_ROWS] = '{
    '{CH_BS,  1'b1, 6'd0, KIND_ECHO, CH_NUL},  // backspace on the empty line after reset
    '{CH_NUL, 1'b1, 6'd0, KIND_ECHO, CH_NUL},  // nul is dropped
    '{CH_TAB, 1'b1, 6'd4, KIND_ECHO, CH_SP},   // full tab, four spaces
    '{8'h61,  1'b1, 6'd1, KIND_ECHO, 8'h61},   // 'a'
    '{CH_BS,  1'b1, 6'd3, KIND_ECHO, CH_BS},   // rubout: bs, space, bs
    '{8'hFF,  1'b1, 6'd1, KIND_ECHO, 8'hFF},   // all ones byte
    '{8'h80,  1'b0, 6'd0, KIND_ECHO, CH_NUL},
    '{8'h7F,  1'b0, 6'd0, KIND_ECHO, CH_NUL},
    '{CH_CR,  1'b0, 6'd0, KIND_ECHO, CH_NUL},  // completes the line, becomes history
    '{CH_ESC, 1'b1, 6'd0, KIND_ECHO, CH_NUL},
    '{8'h5B,  1'b1, 6'd0, KIND_ECHO, CH_NUL},  // '['
    '{CH_UP,  1'b0, 6'd0, KIND_ECHO, CH_NUL},  // arrow up on an empty line: recall
    '{CH_LF,  1'b0, 6'd0, KIND_ECHO, CH_NUL},  // recalled line sent again
    '{CH_LF,  1'b1, 6'd3, KIND_ECHO, CH_CR},   // lone terminator, history kept
    '{CH_ESC, 1'b1, 6'd0, KIND_ECHO, CH_NUL},
    '{CH_UP,  1'b1, 6'd0, KIND_ECHO, CH_NUL},  // 'A' as first byte after esc: swallowed
    '{8'h42,  1'b1, 6'd0, KIND_ECHO, CH_NUL},  // 'B' ends the escape, no recall
    '{8'h71,  1'b1, 6'd1, KIND_ECHO, 8'h71},   // 'q'
    '{CH_ESC, 1'b1, 6'd0, KIND_ECHO, CH_NUL},
    '{8'h5B,  1'b1, 6'd0, KIND_ECHO, CH_NUL},
    '{CH_UP,  1'b1, 6'd0, KIND_ECHO, CH_NUL},  // arrow up on a non-empty line: nothing
    '{CH_CR,  1'b0, 6'd0, KIND_ECHO, CH_NUL},  // history is now a single byte
    '{CH_ESC, 1'b1, 6'd0, KIND_ECHO, CH_NUL},
    '{8'h78,  1'b1, 6'd0, KIND_ECHO, CH_NUL},  // any middle byte will do
    '{CH_UP,  1'b0, 6'd0, KIND_ECHO, CH_NUL}   // recall leaves a line open for the next phase
  };

  // limits of the random phases; the last phase draws its own
  logic [CNT_W-1:0] phase_limits [N_PHASES-1] = '{
    6'd2, 6'd63, 6'd0, 6'd3, 6'd32, 6'd1, 6'd9, 6'd33, 6'd31
  };

  terminal_line_editor i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .data_byte (data_byte),
    .last      (last),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_error(input string what);
    mismatches++;
    if (mismatches <= 10) $display("ERROR: %s", what);
  endtask

  function automatic void add_beat(input logic k, input logic [7:0] d);
    step_beats[step_n] = '{k, d, 1'b0};
    step_n++;
  endfunction

  // send the first dcount stored bytes as a line, keep hcount of them as history
  function automatic void complete_line(input int dcount, input int hcount);
    int i;
    for (i = 0; i < dcount; i++) add_beat(KIND_LINE, line_buf[i]);
    if (hcount > 0) begin
      for (i = 0; i < hcount; i++) hist_buf[i] = line_buf[i];
      hist_len = CNT_W'(hcount);
    end
    fill = '0;
  endfunction

  // edit the line with one received byte and queue the beats it must produce
  function automatic void predict_edit(input logic [7:0] ch);
    int        lim;
    int        i;
    logic      term;
    out_beat_t b;
    step_n = 0;
    // limit register is clamped into the range the line store supports
    if (limit_reg < 2) lim = 2;
    else if (limit_reg > LINE_BUFFER_BYTES) lim = LINE_BUFFER_BYTES;
    else lim = int'(limit_reg);

    if (esc_left != 0) begin
      // inside an escape; 'A' as the closing byte on an empty line recalls history
      esc_left = esc_left - 2'd1;
      if (esc_left == 0 && ch == CH_UP && fill == 0) begin
        for (i = 0; i < hist_len; i++) begin
          line_buf[i] = hist_buf[i];
          add_beat(KIND_ECHO, hist_buf[i]);
        end
        fill = hist_len;
      end
    end else if (ch == CH_BS) begin
      if (fill != 0) begin
        fill = fill - 1'b1;
        add_beat(KIND_ECHO, CH_BS);
        add_beat(KIND_ECHO, CH_SP);
        add_beat(KIND_ECHO, CH_BS);
      end
    end else if (ch == CH_TAB) begin
      // spaces stop short of the completion point, a tab never ends a line
      for (i = 0; i < TAB_SPACES && fill + 2 < lim; i++) begin
        line_buf[fill] = CH_SP;
        add_beat(KIND_ECHO, CH_SP);
        fill = fill + 1'b1;
      end
    end else if (ch == CH_ESC) begin
      esc_left = 2'd2;
    end else if (ch != CH_NUL) begin
      term = (ch == CH_CR || ch == CH_LF);
      if (fill < LINE_BUFFER_BYTES) line_buf[fill] = ch;
      if (term) begin
        add_beat(KIND_ECHO, CH_CR);
        add_beat(KIND_ECHO, CH_LF);
      end else begin
        add_beat(KIND_ECHO, ch);
      end
      if (fill < LINE_BUFFER_BYTES) fill = fill + 1'b1;
      // full line wins over the terminator; a lone terminator keeps the old history
      if (fill >= lim - 1) complete_line(lim - 1, lim - 1);
      else if (term) complete_line(fill, fill - 1);
    end

    for (i = 0; i < step_n; i++) begin
      b      = step_beats[i];
      b.last = (i == step_n - 1);
      pending_beats.push_back(b);
    end
  endfunction

  // everything is sampled at the rising edge, the bench drives at the falling edge
  always @(posedge clk) begin : monitor
    out_beat_t want;
    if (!rst) begin
      if (cfg_we) limit_reg = cfg_data;
      if (in_valid && in_ready) begin
        bytes_in++;
        predict_edit(rx_byte);
      end
      if (out_valid && out_ready) begin
        if (kind == KIND_LINE) line_beats++;
        else echo_beats++;
        if (pending_beats.size() == 0) begin
          flag_error($sformatf("beat with nothing owed: kind %0d data %02h last %0d",
                               kind, data_byte, last));
        end else begin
          want = pending_beats.pop_front();
          if (kind !== want.kind || data_byte !== want.data || last !== want.last)
            flag_error($sformatf(
              "beat differs: expected kind %0d data %02h last %0d, got kind %0d data %02h last %0d",
              want.kind, want.data, want.last, kind, data_byte, last));
        end
      end
    end
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin : watchdog
    wait (cycles >= WATCHDOG_CYCLES);
    $display("timeout after %0d cycles, %0d beats still owed", cycles, pending_beats.size());
    $display("DONE: errors detected");
    $finish;
  end

  // one byte per call; the gap before it is drawn per byte, and often zero
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  // drop valid, let every owed beat drain, then allow for bytes with no beats
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_line_limit(input logic [CNT_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // typing: mostly printable text ended by cr or lf, with edits, recalls and noise
  task automatic type_random_text(input int items, input int term_pct);
    int sent;
    int pick;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // arrow up, half the time on a freshly emptied line so the recall fires
        if ($urandom_range(0, 1) != 0) begin
          send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
          sent++;
        end
        send_byte(CH_ESC);
        send_byte(($urandom_range(0, 3) != 0) ? 8'h5B : 8'($urandom_range(0, 255)));
        send_byte(($urandom_range(0, 4) != 0) ? CH_UP : 8'($urandom_range(0, 255)));
        sent += 3;
      end else if (pick < 8 + term_pct) begin
        send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
        sent++;
      end else if (pick < 14 + term_pct) begin
        send_byte(CH_BS);
        sent++;
      end else if (pick < 19 + term_pct) begin
        send_byte(CH_TAB);
        sent++;
      end else if (pick < 22 + term_pct) begin
        send_byte(CH_NUL);  // ignored by the block, not counted
      end else if (pick < 30 + term_pct) begin
        send_byte(8'($urandom_range(0, 255)));
        sent++;
      end else begin
        send_byte(8'($urandom_range(32, 126)));
        sent++;
      end
    end
  endtask

  // output side: random stall per beat, one long hold when asked
  initial begin : receiver
    int stall;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 17);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int               r;
    int               p;
    logic [CNT_W-1:0] lim;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed bytes at the reset limit
    for (r = 0; r < N_ROWS; r++) begin
      send_byte(dir_rows[r].rx);
      if (dir_rows[r].pin && (step_n != dir_rows[r].n ||
          (step_n != 0 && (step_beats[0].kind != dir_rows[r].kind ||
                           step_beats[0].data != dir_rows[r].data))))
        flag_error($sformatf("byte %02h at row %0d: %0d beats predicted, %0d known",
                             dir_rows[r].rx, r, step_n, dir_rows[r].n));
    end

    // random phases, each under a new limit; the open line carries across
    // so a lowered limit can land on a line already longer than it
    for (p = 0; p < N_PHASES; p++) begin
      wait_quiet();
      lim = (p < N_PHASES - 1) ? phase_limits[p] : CNT_W'($urandom_range(0, 63));
      set_line_limit(lim);
      no_idle = (p == 6);
      if (p == 4) hold_req = 1'b1;  // block fills up while the output is held
      type_random_text(PHASE_ITEMS, (lim >= 20) ? 3 : 10);
    end
    no_idle = 1'b0;
    wait_quiet();

    $display("covered %0d bytes in, %0d echo beats and %0d line beats checked",
             bytes_in, echo_beats, line_beats);
    $display("%0d limit settings incl. clamped ones, one %0d-cycle output hold",
             N_PHASES + 1, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
